// ----- src/digitizer_event_unpacker_defines.svh -----
// assertion macros shared by the digitizer event unpacker rtl
`ifndef DIGITIZER_EVENT_UNPACKER_DEFINES_SVH
`define DIGITIZER_EVENT_UNPACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deu assertion failed");

// next-cycle implication, disabled during reset
`define DEU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deu assertion failed");

`endif

// ----- src/deu_pkg.sv -----
// shared types and constants of the digitizer event unpacker
`default_nettype none

package deu_pkg;

  localparam int unsigned MAX_SPC_DEFAULT    = 65536;
  localparam int unsigned NUM_GROUPS_DEFAULT = 8;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SIZE_W    = 28;
  localparam int unsigned NG_W      = 4;
  localparam int unsigned DIVISOR_W = 5;

  // header word positions
  localparam logic [2:0] HDR_SIZE  = 3'd0;
  localparam logic [2:0] HDR_BOARD = 3'd1;
  localparam logic [2:0] HDR_EVENT = 3'd2;
  localparam logic [2:0] HDR_TIME  = 3'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  accept;
    logic  apply_start;
    logic  store_header;
    logic  div_start;
    logic  load_spc;
    logic  setup;
    logic  emit;
    kind_t emit_kind;
    logic  last;
    logic  sample_step;
    logic  word_end;
    logic  close;
  } deu_cmd_t;

  typedef struct packed {
    logic       start;
    logic       eob;
    logic       in_event;
    logic [2:0] header_count;
    logic       left_zero;
    logic       left_one;
    logic       slot_avail;
    logic       slot_final;
    logic       div_done;
    logic       out_free;
  } deu_stat_t;

endpackage

`default_nettype wire

// ----- src/deu_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module deu_div import deu_pkg::*; #(
  parameter int unsigned N_W = SIZE_W,
  parameter int unsigned D_W = DIVISOR_W
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic      [N_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   rem_next;
  logic [D_W:0]     shifted;
  logic             ge;

  assign shifted  = {rem, quotient[N_W-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign rem_next = ge ? D_W'(shifted - {1'b0, divisor}) : D_W'(shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[N_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- src/deu_ctrl.sv -----
// sequencer of the digitizer event unpacker
`default_nettype none

module deu_ctrl import deu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire deu_stat_t stat,
  output deu_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_WORD  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_SETUP = 9'b000010000,
    S_HDR   = 9'b000100000,
    S_SLOT  = 9'b001000000,
    S_END   = 9'b010000000,
    S_ERR   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.start) begin
          // an open event is abandoned first
          if (stat.in_event) begin
            if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_kind   = KIND_ERROR;
              cmd.last        = !stat.eob;
              cmd.apply_start = 1'b1;
              state_next      = S_WORD;
            end
          end else begin
            cmd.apply_start = 1'b1;
            state_next      = S_WORD;
          end
        end else if (stat.in_event) begin
          state_next = S_WORD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WORD: begin
        if (stat.header_count < HDR_TIME) begin
          cmd.store_header = 1'b1;
          state_next       = stat.eob ? S_ERR : S_IDLE;
        end else if (stat.header_count == HDR_TIME) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_SLOT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.load_spc = 1'b1;
          state_next   = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_HDR;
      end
      S_HDR: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_HEADER;
          cmd.last      = !(stat.eob && !stat.left_zero);
          if (stat.left_zero) begin
            cmd.close  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = stat.eob ? S_ERR : S_IDLE;
          end
        end
      end
      S_SLOT: begin
        if (!stat.slot_avail) begin
          state_next = S_END;
        end else if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_SAMPLE;
          cmd.last        = stat.left_one || (stat.slot_final && !stat.eob);
          cmd.sample_step = 1'b1;
          if (stat.left_one || stat.slot_final) begin
            state_next = S_END;
          end
        end
      end
      S_END: begin
        cmd.word_end = 1'b1;
        if (stat.left_zero) begin
          cmd.close  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = stat.eob ? S_ERR : S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_ERROR;
          cmd.last      = 1'b1;
          cmd.close     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/deu_dp.sv -----
// header store, sample unpacking counters and output register
`default_nettype none

module deu_dp import deu_pkg::*; #(
  parameter int unsigned MAX_SAMPLES_PER_CHANNEL = MAX_SPC_DEFAULT,
  parameter int unsigned NUM_GROUPS              = NUM_GROUPS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              start_req,
  input  wire logic              end_of_bank,
  input  wire deu_cmd_t          cmd,
  output deu_stat_t              stat,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             kind,
  output logic [3:0]             source_id,
  output logic [27:0]            event_size,
  output logic [4:0]             board_id,
  output logic [15:0]            pattern,
  output logic [7:0]             groups_enabled,
  output logic [23:0]            event_number,
  output logic [31:0]            time_tag,
  output logic [5:0]             channel,
  output logic [15:0]            sample_index,
  output logic [11:0]            sample_value,
  output logic                   last
);

  localparam int unsigned SPC_W   = $clog2(MAX_SAMPLES_PER_CHANNEL + 1);
  localparam int unsigned GLEFT_W = SPC_W + 3;
  localparam int unsigned LEFT_W  = SPC_W + 6;
  localparam logic [7:0]  GROUPS_FITTED = 8'((9'd1 << NUM_GROUPS) - 9'd1);

  function automatic logic [2:0] next_group(input logic [7:0] mask, input logic [3:0] from);
    logic [2:0] g_sel;
    g_sel = '0;
    for (int g = 7; g >= 0; g--) begin
      if (4'(g) >= from && mask[g]) g_sel = 3'(g);
    end
    return g_sel;
  endfunction

  function automatic logic [NG_W-1:0] popcount8(input logic [7:0] v);
    logic [NG_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + NG_W'(v[i]);
    return n;
  endfunction

  // latched input beat
  logic [WORD_W-1:0] w_q;
  logic              start_q;
  logic              eob_q;

  // event state
  logic               in_event;
  logic [2:0]         header_count;
  logic [1:0]         word_phase;
  logic [7:0]         carry_bits;
  logic [7:0]         mask_store;
  logic [SPC_W-1:0]   spc;
  logic [2:0]         active_group;
  logic [2:0]         chan_in_group;
  logic [1:0]         triplet_pos;
  logic [15:0]        sample_base;
  logic [LEFT_W-1:0]  samples_left;
  logic [GLEFT_W-1:0] group_left;
  logic [1:0]         slot;

  // held header fields
  logic [3:0]  h_src;
  logic [27:0] h_size;
  logic [4:0]  h_board;
  logic [15:0] h_pat;
  logic [7:0]  h_mask;
  logic [23:0] h_evn;

  logic [7:0]           mask_used;
  logic [NG_W-1:0]      ng;
  logic [DIVISOR_W-1:0] divisor;
  logic                 div_done;
  logic [SIZE_W-1:0]    quotient;
  logic [1:0]           nslots;
  logic [11:0]          slot_value;
  logic [LEFT_W-1:0]    sl_dec;
  logic [GLEFT_W-1:0]   gl_dec;

  assign mask_used = h_mask & GROUPS_FITTED;
  assign ng        = popcount8(mask_used);
  assign divisor   = DIVISOR_W'(ng) * DIVISOR_W'(3);

  deu_div #(
    .N_W (SIZE_W),
    .D_W (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (h_size),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign nslots = (word_phase == 2'd0) ? 2'd2 : 2'd3;

  // twelve-bit sample picked from the current word and the carried bits
  always_comb begin
    case (word_phase)
      2'd0: begin
        case (slot)
          2'd0:    slot_value = w_q[11:0];
          default: slot_value = w_q[23:12];
        endcase
      end
      2'd1: begin
        case (slot)
          2'd0:    slot_value = {w_q[3:0], carry_bits};
          2'd1:    slot_value = w_q[15:4];
          default: slot_value = w_q[27:16];
        endcase
      end
      default: begin
        case (slot)
          2'd0:    slot_value = {w_q[7:0], carry_bits[3:0]};
          2'd1:    slot_value = w_q[19:8];
          default: slot_value = w_q[31:20];
        endcase
      end
    endcase
  end

  assign sl_dec = samples_left - LEFT_W'(1);
  assign gl_dec = (group_left != '0) ? group_left - GLEFT_W'(1) : '0;

  always_comb begin
    stat              = '0;
    stat.start        = start_q;
    stat.eob          = eob_q;
    stat.in_event     = in_event;
    stat.header_count = header_count;
    stat.left_zero    = (samples_left == '0);
    stat.left_one     = (samples_left == LEFT_W'(1));
    stat.slot_avail   = (samples_left != '0) && (slot < nslots);
    stat.slot_final   = (slot == nslots - 2'd1);
    stat.div_done     = div_done;
    stat.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      w_q     <= word;
      start_q <= start_req;
      eob_q   <= end_of_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_header) begin
      case (header_count)
        HDR_SIZE: begin
          h_src  <= w_q[31:28];
          h_size <= w_q[27:0];
        end
        HDR_BOARD: begin
          h_board <= w_q[31:27];
          h_pat   <= w_q[23:8];
          h_mask  <= w_q[7:0];
        end
        HDR_EVENT: h_evn <= w_q[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_event      <= 1'b0;
      header_count  <= '0;
      word_phase    <= '0;
      carry_bits    <= '0;
      mask_store    <= '0;
      spc           <= '0;
      active_group  <= '0;
      chan_in_group <= '0;
      triplet_pos   <= '0;
      sample_base   <= '0;
      samples_left  <= '0;
      group_left    <= '0;
      slot          <= '0;
    end else begin
      if (cmd.accept) slot <= '0;
      if (cmd.apply_start) begin
        in_event     <= 1'b1;
        header_count <= '0;
        samples_left <= '0;
        word_phase   <= '0;
        carry_bits   <= '0;
      end
      if (cmd.store_header) header_count <= header_count + 3'd1;
      if (cmd.load_spc) begin
        if (ng == '0) begin
          spc <= '0;
        end else if (quotient > SIZE_W'(MAX_SAMPLES_PER_CHANNEL)) begin
          spc <= SPC_W'(MAX_SAMPLES_PER_CHANNEL);
        end else begin
          spc <= SPC_W'(quotient);
        end
      end
      if (cmd.setup) begin
        header_count  <= header_count + 3'd1;
        mask_store    <= mask_used;
        samples_left  <= LEFT_W'(LEFT_W'(ng) * LEFT_W'(spc)) << 3;
        group_left    <= GLEFT_W'(spc) << 3;
        active_group  <= next_group(mask_used, 4'd0);
        chan_in_group <= '0;
        triplet_pos   <= '0;
        sample_base   <= '0;
        word_phase    <= '0;
        carry_bits    <= '0;
      end
      if (cmd.sample_step) begin
        slot         <= slot + 2'd1;
        samples_left <= sl_dec;
        if (gl_dec == '0 && sl_dec != '0) begin
          // move on to the next enabled group
          active_group  <= next_group(mask_store, {1'b0, active_group} + 4'd1);
          chan_in_group <= '0;
          triplet_pos   <= '0;
          sample_base   <= '0;
          group_left    <= GLEFT_W'(spc) << 3;
        end else begin
          group_left <= gl_dec;
          if (triplet_pos == 2'd2) begin
            triplet_pos   <= '0;
            chan_in_group <= chan_in_group + 3'd1;
            if (chan_in_group == 3'd7) sample_base <= sample_base + 16'd3;
          end else begin
            triplet_pos <= triplet_pos + 2'd1;
          end
        end
      end
      if (cmd.word_end) begin
        case (word_phase)
          2'd0: begin
            carry_bits <= w_q[31:24];
            word_phase <= 2'd1;
          end
          2'd1: begin
            carry_bits <= {4'd0, w_q[31:28]};
            word_phase <= 2'd2;
          end
          default: begin
            carry_bits <= '0;
            word_phase <= 2'd0;
          end
        endcase
      end
      if (cmd.close) begin
        in_event     <= 1'b0;
        samples_left <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind           <= cmd.emit_kind;
      last           <= cmd.last;
      source_id      <= '0;
      event_size     <= '0;
      board_id       <= '0;
      pattern        <= '0;
      groups_enabled <= '0;
      event_number   <= '0;
      time_tag       <= '0;
      channel        <= '0;
      sample_index   <= '0;
      sample_value   <= '0;
      case (cmd.emit_kind)
        KIND_SAMPLE: begin
          channel      <= {active_group, chan_in_group};
          sample_index <= sample_base + 16'(triplet_pos);
          sample_value <= slot_value;
        end
        KIND_HEADER: begin
          source_id      <= h_src;
          event_size     <= h_size;
          board_id       <= h_board;
          pattern        <= h_pat;
          groups_enabled <= h_mask;
          event_number   <= h_evn;
          time_tag       <= w_q;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/digitizer_event_unpacker.sv -----
// top level of the digitizer event unpacker
//
// input channel: one 32-bit bank word per beat, with start_req on the first
// word of a bank and end_of_bank on the last word present.
// output channel: one result per beat, kind 0 sample, 1 event header,
// 2 truncated event error; last marks the final result caused by one word.
// a word is held while its results go out one per cycle, as long as the
// receiver does not stall, through an output register, so the next word
// is taken while the final beat still waits. the fourth header word waits
// on the one-bit-per-cycle divider that works out samples per channel
// before the header beat is given. a stalled receiver holds the sequencer
// on its current result; nothing is dropped. synchronous reset closes any
// open event and empties the output register; no clearing pass is needed
// and a word is taken the cycle after.
`default_nettype none

`include "digitizer_event_unpacker_defines.svh"

module digitizer_event_unpacker import deu_pkg::*; #(
  parameter int unsigned MAX_SAMPLES_PER_CHANNEL = MAX_SPC_DEFAULT,
  parameter int unsigned NUM_GROUPS              = NUM_GROUPS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] word,
  input  wire logic        start_req,
  input  wire logic        end_of_bank,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [3:0]       source_id,
  output logic [27:0]      event_size,
  output logic [4:0]       board_id,
  output logic [15:0]      pattern,
  output logic [7:0]       groups_enabled,
  output logic [23:0]      event_number,
  output logic [31:0]      time_tag,
  output logic [5:0]       channel,
  output logic [15:0]      sample_index,
  output logic [11:0]      sample_value,
  output logic             last
);

  // commands from the sequencer, status back from the datapath
  deu_cmd_t  cmd;
  deu_stat_t stat;

  // all sample fields at zero
  logic sample_clear;

  deu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // header store, unpacking counters, divider and output register
  deu_dp #(
    .MAX_SAMPLES_PER_CHANNEL (MAX_SAMPLES_PER_CHANNEL),
    .NUM_GROUPS              (NUM_GROUPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .word           (word),
    .start_req      (start_req),
    .end_of_bank    (end_of_bank),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .kind           (kind),
    .source_id      (source_id),
    .event_size     (event_size),
    .board_id       (board_id),
    .pattern        (pattern),
    .groups_enabled (groups_enabled),
    .event_number   (event_number),
    .time_tag       (time_tag),
    .channel        (channel),
    .sample_index   (sample_index),
    .sample_value   (sample_value),
    .last           (last)
  );

  assign sample_clear = (channel == 6'd0) && (sample_index == 16'd0) && (sample_value == 12'd0);

  // a waiting beat is never overwritten
  `DEU_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, stat.out_free)
  // every loaded result is offered on the next cycle
  `DEU_ASSERT_NXT(a_emit_shown, clk, rst, cmd.emit, out_valid)
  // sample fields stay clear outside sample beats
  `DEU_ASSERT_IMP(a_hdr_clean, clk, rst, out_valid && kind != KIND_SAMPLE, sample_clear)

endmodule

`default_nettype wire

// ----- sim/deu_result_checker.sv -----
// beat checker for the digitizer event unpacker: mirrors the unpacking and compares results
module deu_result_checker import deu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] word,
  input  wire logic        start_req,
  input  wire logic        end_of_bank,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  source_id,
  input  wire logic [27:0] event_size,
  input  wire logic [4:0]  board_id,
  input  wire logic [15:0] pattern,
  input  wire logic [7:0]  groups_enabled,
  input  wire logic [23:0] event_number,
  input  wire logic [31:0] time_tag,
  input  wire logic [5:0]  channel,
  input  wire logic [15:0] sample_index,
  input  wire logic [11:0] sample_value,
  input  wire logic        last,
  output int               fail_count,
  output int               pending
);

  localparam int unsigned GROUPS  = NUM_GROUPS_DEFAULT;
  localparam int unsigned MAX_SPC = MAX_SPC_DEFAULT;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  src;
    logic [27:0] size;
    logic [4:0]  board;
    logic [15:0] pat;
    logic [7:0]  mask;
    logic [23:0] evn;
    logic [31:0] ttag;
    logic [5:0]  chan;
    logic [15:0] idx;
    logic [11:0] val;
    logic        last;
  } unpack_beat_t;

  unpack_beat_t beats_due[$];
  unpack_beat_t word_beats[$];

  bit [2:0]  hdr_cnt;
  bit        ev_open;
  bit [1:0]  phase;
  bit [7:0]  carry;
  bit [7:0]  grp_mask;
  bit [16:0] spc;
  bit [2:0]  cur_grp;
  bit [2:0]  chan_sub;
  bit [1:0]  trip;
  bit [15:0] idx_base;
  bit [22:0] left_total;
  bit [19:0] left_grp;
  bit [3:0]  h_src;
  bit [27:0] h_size;
  bit [4:0]  h_board;
  bit [15:0] h_pat;
  bit [7:0]  h_mask;
  bit [23:0] h_evn;

  function automatic unpack_beat_t blank_beat(kind_t k);
    unpack_beat_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic bit [2:0] first_group_from(int unsigned from);
    for (int unsigned g = from; g < GROUPS && g < 8; g++)
      if (grp_mask[g]) return 3'(g);
    return 3'd0;
  endfunction

  function automatic void take_sample(logic [11:0] v);
    unpack_beat_t r;
    if (left_total == 0) return;
    r = blank_beat(KIND_SAMPLE);
    r.chan = {cur_grp, chan_sub};
    r.idx  = idx_base + 16'(trip);
    r.val  = v;
    word_beats.push_back(r);
    left_total--;
    if (left_grp != 0) left_grp--;
    // three indices per channel, then on to the next channel
    if (trip == 2'd2) begin
      trip = 2'd0;
      if (chan_sub == 3'd7) idx_base += 16'd3;
      chan_sub++;
    end else begin
      trip++;
    end
    if (left_grp == 0 && left_total != 0) begin
      cur_grp  = first_group_from(int'(cur_grp) + 1);
      chan_sub = 3'd0;
      trip     = 2'd0;
      idx_base = 16'd0;
      left_grp = 20'(8 * spc);
    end
  endfunction

  function automatic void open_samples();
    int unsigned ng;
    int unsigned q;
    grp_mask = h_mask & 8'((1 << GROUPS) - 1);
    ng = $countones(grp_mask);
    if (ng == 0) begin
      spc = '0;
    end else begin
      q = h_size / (3 * ng);
      spc = (q > MAX_SPC) ? 17'(MAX_SPC) : 17'(q);
    end
    left_total = 23'(ng * 8 * spc);
    left_grp   = 20'(8 * spc);
    cur_grp    = first_group_from(0);
    chan_sub   = '0;
    trip       = '0;
    idx_base   = '0;
    phase      = '0;
    carry      = '0;
  endfunction

  function automatic void unpack_word(logic [31:0] w, logic st, logic eob);
    unpack_beat_t r;
    word_beats.delete();
    if (st) begin
      // an event still open is abandoned with an error beat
      if (ev_open) word_beats.push_back(blank_beat(KIND_ERROR));
      ev_open    = 1'b1;
      hdr_cnt    = '0;
      left_total = '0;
      phase      = '0;
      carry      = '0;
    end
    if (ev_open) begin
      if (hdr_cnt < 3'd4) begin
        case (hdr_cnt)
          HDR_SIZE: begin
            h_src  = w[31:28];
            h_size = w[27:0];
          end
          HDR_BOARD: begin
            h_board = w[31:27];
            h_pat   = w[23:8];
            h_mask  = w[7:0];
          end
          HDR_EVENT: h_evn = w[23:0];
          default: begin
            r       = blank_beat(KIND_HEADER);
            r.src   = h_src;
            r.size  = h_size;
            r.board = h_board;
            r.pat   = h_pat;
            r.mask  = h_mask;
            r.evn   = h_evn;
            r.ttag  = w;
            word_beats.push_back(r);
            open_samples();
          end
        endcase
        hdr_cnt++;
      end else begin
        case (phase)
          2'd0: begin
            take_sample(w[11:0]);
            take_sample(w[23:12]);
            carry = w[31:24];
            phase = 2'd1;
          end
          2'd1: begin
            take_sample({w[3:0], carry});
            take_sample(w[15:4]);
            take_sample(w[27:16]);
            carry = {4'd0, w[31:28]};
            phase = 2'd2;
          end
          default: begin
            take_sample({w[7:0], carry[3:0]});
            take_sample(w[19:8]);
            take_sample(w[31:20]);
            carry = '0;
            phase = 2'd0;
          end
        endcase
      end
      if (hdr_cnt >= 3'd4 && left_total == 0) ev_open = 1'b0;
      // bank ended short: error after any samples of this word
      if (eob && ev_open) begin
        word_beats.push_back(blank_beat(KIND_ERROR));
        ev_open    = 1'b0;
        left_total = '0;
      end
    end
    if (word_beats.size() > 0) word_beats[word_beats.size() - 1].last = 1'b1;
    foreach (word_beats[i]) beats_due.push_back(word_beats[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    unpack_beat_t b;
    if (rst) begin
      beats_due.delete();
      hdr_cnt    = '0;
      ev_open    = 1'b0;
      left_total = '0;
      left_grp   = '0;
      pending   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          $error("result beat with nothing due, kind %0d", kind);
          fail_count++;
        end else begin
          b = beats_due.pop_front();
          check_field("kind", b.kind, kind);
          check_field("source_id", b.src, source_id);
          check_field("event_size", b.size, event_size);
          check_field("board_id", b.board, board_id);
          check_field("pattern", b.pat, pattern);
          check_field("groups_enabled", b.mask, groups_enabled);
          check_field("event_number", b.evn, event_number);
          check_field("time_tag", b.ttag, time_tag);
          check_field("channel", b.chan, channel);
          check_field("sample_index", b.idx, sample_index);
          check_field("sample_value", b.val, sample_value);
          check_field("last", b.last, last);
        end
      end
      if (in_valid && in_ready) unpack_word(word, start_req, end_of_bank);
      pending <= beats_due.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// testbench top for the digitizer event unpacker: stimulus, receiver stalls and verdict
module tb;
  import deu_pkg::*;

  // generous ceiling, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TARGET_WORDS = 260;
  // long receiver hold-off, enough to fill the block and stall its input
  localparam int unsigned HOLD_CYCLES  = 400;
  // drain time covers the divider run of the fourth header word
  localparam int unsigned DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] word = '0;
  logic        start_req = 1'b0;
  logic        end_of_bank = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  source_id;
  logic [27:0] event_size;
  logic [4:0]  board_id;
  logic [15:0] pattern;
  logic [7:0]  groups_enabled;
  logic [23:0] event_number;
  logic [31:0] time_tag;
  logic [5:0]  channel;
  logic [15:0] sample_index;
  logic [11:0] sample_value;
  logic        last;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  bit          hold_req = 1'b0;

  digitizer_event_unpacker DUT (.*);

  deu_result_checker result_check (.*);

  always #10 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one beat on the input channel, entered and left at a falling edge;
  // the sender works in bursts and idles between them
  task automatic send_word(input logic [31:0] w, input logic st, input logic eob);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid    <= 1'b1;
    word        <= w;
    start_req   <= st;
    end_of_bank <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // words a complete bank needs: four headers plus the packed samples
  function automatic int unsigned full_words(logic [7:0] mask, logic [27:0] size);
    int unsigned ng;
    int unsigned spc;
    ng = $countones(mask);
    if (ng == 0) return 4;
    spc = size / (3 * ng);
    if (spc > MAX_SPC_DEFAULT) spc = MAX_SPC_DEFAULT;
    return 4 + (ng * 8 * spc * 3 + 7) / 8;
  endfunction

  // event size giving the wanted samples per channel, with a random remainder
  function automatic logic [27:0] size_for(logic [7:0] mask, int unsigned spc);
    int unsigned ng;
    ng = $countones(mask);
    if (ng == 0) return 28'($urandom_range(0, 5000));
    return 28'(3 * ng * spc + $urandom_range(0, 3 * ng - 1));
  endfunction

  // sends the first n_words of a bank, end_of_bank on the final one if asked
  task automatic send_event(input logic [7:0] mask, input logic [27:0] size,
                            input int unsigned n_words, input bit eob_last, input bit flat);
    logic [31:0] w;
    for (int unsigned k = 0; k < n_words; k++) begin
      case (k)
        HDR_SIZE:  w = {4'($urandom), size};
        HDR_BOARD: w = {5'($urandom), 3'($urandom), 16'($urandom), mask};
        HDR_EVENT: w = {8'($urandom), 24'($urandom)};
        HDR_TIME:  w = $urandom;
        // flat data swings every bit between all ones and all zeros
        default:   w = flat ? ((k % 2 == 0) ? 32'hFFFF_FFFF : 32'h0) : $urandom;
      endcase
      send_word(w, k == 0, eob_last && (k == n_words - 1));
      words_sent++;
    end
  endtask

  // receiver: stall pattern changes every so often, plus one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int unsigned n = 0; n < span; n++) begin
        @(negedge clk);
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (n % 4 != 3);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned ev;
    int unsigned spc;
    int unsigned nfull;
    logic [7:0]  mask;
    logic [27:0] size;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed part
    // stray beat while no event is open, carrying end_of_bank too
    send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
    // one group, one sample per channel: partial last triplet; end_of_bank
    // on the word that completes the event is ignored
    send_event(8'h01, 28'd3, full_words(8'h01, 28'd3), 1'b1, 1'b1);
    // no group enabled: header only, no samples
    send_event(8'h00, 28'd0, 4, 1'b1, 1'b0);
    // bank ends during the header words
    send_event(8'h06, size_for(8'h06, 1), 2, 1'b1, 1'b0);
    // abandoned in the data words, the next start closes it with an error
    send_event(8'h24, size_for(8'h24, 2), 6, 1'b0, 1'b0);
    // largest size on the top group: samples per channel saturate, bank cut short
    send_event(8'h80, 28'h0FFF_FFFF, 7, 1'b1, 1'b1);

    // random part: mostly well-formed banks with random content
    ev = 0;
    while (words_sent < TARGET_WORDS) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       mask = 8'h00;
        1:       mask = 8'hFF;
        default: begin
          mask = 8'(1 << $urandom_range(0, 7));
          if ($urandom_range(0, 2) == 0) mask |= 8'(1 << $urandom_range(0, 7));
        end
      endcase
      spc   = (mask == 8'hFF) ? $urandom_range(0, 1) : $urandom_range(0, 5);
      size  = size_for(mask, spc);
      nfull = full_words(mask, size);
      // the long hold-off lands early in the random part
      if (ev == 3) hold_req = 1'b1;
      // some noise between banks
      if ($urandom_range(0, 9) == 0) send_word($urandom, 1'b0, 1'($urandom_range(0, 1)));
      if (pick < 65) begin
        send_event(mask, size, nfull, 1'($urandom_range(0, 1)), 1'b0);
      end else if (pick < 78) begin
        // short bank inside the data words
        send_event(mask, size, (nfull > 5) ? $urandom_range(5, nfull) : nfull, 1'b1, 1'b0);
      end else if (pick < 86) begin
        // short bank during the header
        send_event(mask, size, $urandom_range(1, 4), 1'b1, 1'b0);
      end else if (pick < 95) begin
        // left open, the next start abandons it
        send_event(mask, size, $urandom_range(1, nfull), 1'b0, 1'b0);
      end else begin
        // near the largest size, saturated and cut short
        if (mask == 8'h00) mask = 8'h10;
        send_event(mask, 28'h0FFF_FFFF - 28'($urandom_range(0, 1000)),
                   $urandom_range(5, 12), 1'b1, 1'b0);
      end
      ev++;
    end
    in_valid <= 1'b0;

    // let every due beat come out, then a little longer for stragglers
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- digitizer_event_unpacker.f -----
+incdir+src
src/deu_pkg.sv
src/deu_div.sv
src/deu_ctrl.sv
src/deu_dp.sv
src/digitizer_event_unpacker.sv
sim/deu_result_checker.sv
sim/tb.sv
